[sv/triangle_tangent_bitangent_macros.svh]
// assertion helpers for the asserting module triangle_tangent_bitangent
`ifndef TRIANGLE_TANGENT_BITANGENT_MACROS_SVH
`define TRIANGLE_TANGENT_BITANGENT_MACROS_SVH

// property checked on every clock edge outside reset
`define TTB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// property checked on every clock edge, reset included
`define TTB_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/ttb_pkg.sv]
package ttb_pkg;

	// field geometry
	localparam int unsigned FieldW  = 32;
	localparam int unsigned DiffW   = FieldW + 1;
	localparam int unsigned ProdW   = 2 * DiffW;
	localparam int unsigned AccW    = ProdW + 1;
	localparam int unsigned FracW   = 16;
	localparam int unsigned NumW    = AccW + FracW;
	localparam int unsigned DshW    = AccW + FieldW - 1;
	localparam int unsigned CmpW    = AccW + FieldW;
	localparam int unsigned CompN   = 6;

	// sequencer state codes
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL_A = 3'd1;
	localparam logic [2:0] ST_MUL_B = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	// saturation limits
	localparam logic [FieldW-1:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [FieldW-1:0] SAT_NEG = 32'h8000_0000;

endpackage

[sv/triangle_tangent_bitangent.sv]
// Per-triangle tangent and bitangent unit.
// Input channel s_axis_*: one vertex per transaction, position xyz and
// texture uv, all signed Q16.16. The first two corners of a triangle are
// stored. The third corner starts the computation.
// Output channel m_axis_*: one transaction per triangle carrying tangent and
// bitangent in Q16.16 (saturated) and the degenerate flag in tuser.
// The computation uses one shared 33x33 multiplier that forms 14 products
// and one shared restoring divider that forms six quotients, and then loads
// the result into the output register; a zero determinant ends after the
// first two products.
// s_axis_tready is high only while the sequencer is idle.
// The result waits in an output register; the next triangle's corners are
// taken while it waits, and a finished triangle stalls until it is free.
// Reset (arst_n low) clears the corner count, the sequencer and the output
// valid; stored corners are not cleared and are always written before use.
module triangle_tangent_bitangent
	import ttb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	// pos_x, pos_y, pos_z, tex_u, tex_v
	input  logic [159:0]       s_axis_tdata,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// tangent_x/y/z, bitangent_x/y/z
	output logic [191:0]       m_axis_tdata,
	// degenerate
	output logic [0:0]         m_axis_tuser
);

	logic [2:0]               state_q;
	logic [1:0]               corner_q;
	logic [FieldW-1:0]        pos_q [6];
	logic [FieldW-1:0]        tex_q [4];
	logic signed [DiffW-1:0]  e1_q [3];
	logic signed [DiffW-1:0]  e2_q [3];
	logic signed [DiffW-1:0]  du1_q, dv1_q, du2_q, dv2_q;
	logic [2:0]               c_q;
	logic                     ph_q;
	logic signed [ProdW-1:0]  prod_q;
	logic signed [AccW-1:0]   acc_q, det_q, acc_nxt;
	logic [DshW-1:0]          rem_q, dsh_q;
	logic [FieldW-1:0]        quo_q;
	logic [4:0]               it_q;
	logic                     neg_q, ovf_q, degen_q;
	logic [FieldW-1:0]        res_q [CompN];
	logic                     out_valid_q;
	logic [191:0]             out_data_q;
	logic                     out_degen_q;

	logic                     in_acc;
	logic signed [FieldW-1:0] in_f [5];
	logic signed [DiffW-1:0]  op_a, op_b;
	logic [1:0]               k_idx;
	logic [2:0]               j_idx;
	logic [AccW-1:0]          nmag, dmag;
	logic [NumW-1:0]          nsh;
	logic                     ovf;
	logic [DshW:0]            trial;
	logic [FieldW-1:0]        sat_res;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_degen_q;

	// unpack vertex fields
	always_comb begin
		for (int f = 0; f < 5; f++) begin
			in_f[f] = s_axis_tdata[f*FieldW +: FieldW];
		end
	end

	// operand select for the shared multiplier
	always_comb begin
		op_a  = du1_q;
		op_b  = dv2_q;
		k_idx = 2'd0;
		if (c_q >= 3'd4) begin
			k_idx = 2'(c_q - 3'd4);
		end else if (c_q != 3'd0) begin
			k_idx = 2'(c_q - 3'd1);
		end
		case (c_q)
			3'd0: begin
				op_a = ph_q ? du2_q : du1_q;
				op_b = ph_q ? dv1_q : dv2_q;
			end
			3'd1, 3'd2, 3'd3: begin
				op_a = ph_q ? dv1_q : dv2_q;
				op_b = ph_q ? e2_q[k_idx] : e1_q[k_idx];
			end
			default: begin
				op_a = ph_q ? du2_q : du1_q;
				op_b = ph_q ? e1_q[k_idx] : e2_q[k_idx];
			end
		endcase
	end

	// second product of a pair is subtracted
	assign acc_nxt = acc_q - AccW'(prod_q);

	// divider setup from the finished numerator
	always_comb begin
		nmag = acc_nxt[AccW-1] ? AccW'(-acc_nxt) : AccW'(acc_nxt);
		dmag = det_q[AccW-1] ? AccW'(-det_q) : AccW'(det_q);
		nsh  = {nmag, {FracW{1'b0}}};
		ovf  = (CmpW'(nsh) >= {dmag, {FieldW{1'b0}}});
	end

	assign trial = {1'b0, rem_q} - {1'b0, dsh_q};
	assign j_idx = c_q - 3'd1;

	// saturate and sign the quotient
	always_comb begin
		if (!neg_q) begin
			sat_res = (ovf_q || quo_q[FieldW-1]) ? SAT_POS : quo_q;
		end else if (ovf_q || quo_q > SAT_NEG) begin
			sat_res = SAT_NEG;
		end else begin
			sat_res = -quo_q;
		end
	end

	// corner storage and edge differences
	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (corner_q != 2'd2) begin
				for (int k = 0; k < 3; k++) begin
					pos_q[3'(corner_q[0] * 3 + k)] <= in_f[k];
				end
				tex_q[{corner_q[0], 1'b0}] <= in_f[3];
				tex_q[{corner_q[0], 1'b1}] <= in_f[4];
			end else begin
				for (int k = 0; k < 3; k++) begin
					e1_q[k] <= DiffW'($signed(pos_q[3+k])) - DiffW'($signed(pos_q[k]));
					e2_q[k] <= DiffW'(in_f[k]) - DiffW'($signed(pos_q[k]));
				end
				du1_q <= DiffW'($signed(tex_q[2])) - DiffW'($signed(tex_q[0]));
				dv1_q <= DiffW'($signed(tex_q[3])) - DiffW'($signed(tex_q[1]));
				du2_q <= DiffW'(in_f[3]) - DiffW'($signed(tex_q[0]));
				dv2_q <= DiffW'(in_f[4]) - DiffW'($signed(tex_q[1]));
			end
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			corner_q    <= 2'd0;
			c_q         <= 3'd0;
			ph_q        <= 1'b0;
			it_q        <= 5'd0;
			out_valid_q <= 1'b0;
		end else begin
			// output valid set on load, cleared once taken
			if (state_q == ST_OUT && (!out_valid_q || m_axis_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (corner_q == 2'd2) begin
							corner_q <= 2'd0;
							c_q      <= 3'd0;
							ph_q     <= 1'b0;
							state_q  <= ST_MUL_A;
						end else begin
							corner_q <= corner_q + 2'd1;
						end
					end
				end
				ST_MUL_A: begin
					state_q <= ST_MUL_B;
				end
				ST_MUL_B: begin
					if (!ph_q) begin
						ph_q    <= 1'b1;
						state_q <= ST_MUL_A;
					end else if (c_q == 3'd0) begin
						ph_q    <= 1'b0;
						c_q     <= 3'd1;
						state_q <= (acc_nxt == '0) ? ST_OUT : ST_MUL_A;
					end else begin
						it_q    <= 5'd0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					it_q <= it_q + 5'd1;
					if (it_q == 5'd31) begin
						ph_q <= 1'b0;
						if (c_q == 3'(CompN)) begin
							state_q <= ST_OUT;
						end else begin
							c_q     <= c_q + 3'd1;
							state_q <= ST_MUL_A;
						end
					end
				end
				ST_OUT: begin
					if (!out_valid_q || m_axis_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// shared multiplier, accumulator and divider datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_MUL_A: begin
				prod_q <= op_a * op_b;
			end
			ST_MUL_B: begin
				if (!ph_q) begin
					acc_q <= AccW'(prod_q);
				end else if (c_q == 3'd0) begin
					det_q   <= acc_nxt;
					degen_q <= (acc_nxt == '0);
				end else begin
					neg_q  <= acc_nxt[AccW-1] ^ det_q[AccW-1];
					ovf_q  <= ovf;
					rem_q  <= DshW'(nsh);
					dsh_q  <= {dmag, {(FieldW-1){1'b0}}};
				end
			end
			ST_DIV: begin
				if (!trial[DshW]) begin
					rem_q <= trial[DshW-1:0];
				end
				quo_q <= {quo_q[FieldW-2:0], !trial[DshW]};
				dsh_q <= dsh_q >> 1;
			end
			default: begin
			end
		endcase
	end

	// write back each finished quotient
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL_A && c_q >= 3'd2 && !ph_q && !degen_q) begin
			res_q[3'(c_q - 3'd2)] <= sat_res;
		end
		if (state_q == ST_OUT && !degen_q) begin
			res_q[CompN-1] <= sat_res;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!out_valid_q || m_axis_tready)) begin
			for (int j = 0; j < CompN; j++) begin
				out_data_q[j*FieldW +: FieldW] <= (degen_q || j_idx == 3'(j)) ?
					((degen_q) ? '0 : sat_res) : res_q[j];
			end
			out_degen_q <= degen_q;
		end
	end

	`include "triangle_tangent_bitangent_macros.svh"

	`TTB_ASSERT(a_count_clear, (state_q != ST_IDLE) |-> (corner_q == 2'd0), "corner count not cleared during compute")
	`TTB_ASSERT(a_count_range, corner_q != 2'd3, "corner count out of range")
	`TTB_ASSERT(a_valid_src, $rose(m_axis_tvalid) |-> ($past(state_q) == ST_OUT), "result raised outside output state")

endmodule
